// ===== rtl/core/uartrx_pkg.sv =====
// Package for the UART receive deframer.
// Holds register reset values, register indexes and the shared structs.
// No dependencies.
package uartrx_pkg;

	// register file geometry
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS = 2'd1;

	// register reset values
	localparam logic [15:0] BIT_TICKS_RST = 16'd104;
	localparam logic [16:0] HOLDOFF_TICKS_RST = 17'd114;

	// default buffer depth
	localparam int BUF_DEPTH_DEF = 64;

	typedef struct packed {
		logic [15:0] bit_ticks;
		logic [16:0] holdoff_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       framing_error;
		logic       stored;
		logic [5:0] slot;
		logic       overflow;
	} result_t;

endpackage

// ===== rtl/core/uartrx_cfg.sv =====
// Configuration register file of the UART receive deframer.
// Depends on uartrx_pkg.
module uartrx_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [uartrx_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [uartrx_pkg::CFG_DATA_W-1:0]    wr_data,
	output uartrx_pkg::cfg_t                     cfg
);

	logic [15:0] bit_ticks_q;
	logic [16:0] holdoff_ticks_q;

	// write the addressed register, drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q     <= uartrx_pkg::BIT_TICKS_RST;
			holdoff_ticks_q <= uartrx_pkg::HOLDOFF_TICKS_RST;
		end else if (wr_en) begin
			if (wr_index == uartrx_pkg::REG_BIT_TICKS) begin
				bit_ticks_q <= wr_data[15:0];
			end else if (wr_index == uartrx_pkg::REG_HOLDOFF_TICKS) begin
				holdoff_ticks_q <= wr_data[16:0];
			end
		end
	end

	assign cfg.bit_ticks     = bit_ticks_q;
	assign cfg.holdoff_ticks = holdoff_ticks_q;

endmodule

// ===== rtl/core/uartrx_fsm.sv =====
// Frame state machine of the UART receive deframer: bit timing, shift
// register, fill count and result formation. Depends on uartrx_pkg.
module uartrx_fsm #(
	parameter int BUF_DEPTH = uartrx_pkg::BUF_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                level,
	input  uartrx_pkg::cfg_t    cfg,
	output logic                res_valid,
	output uartrx_pkg::result_t res
);

	localparam int FILL_W = $clog2(BUF_DEPTH + 1);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RECV = 2'd1;
	localparam logic [1:0] PH_HOLD = 2'd2;

	logic [1:0]        phase_q, phase_n;
	logic [16:0]       tick_q, tick_n;
	logic [3:0]        idx_q, idx_n;
	logic [7:0]        shift_q, shift_n;
	logic              prev_q;
	logic [FILL_W-1:0] fill_q, fill_n;

	logic [16:0]       tick_inc;
	logic [16:0]       target;
	logic [FILL_W+5:0] fill_ext;

	assign tick_inc = tick_q + 17'd1;
	assign fill_ext = {6'd0, fill_q};

	// first data bit waits one and a half bit periods, later bits one
	always_comb begin
		if (idx_q == 4'd0) begin
			target = {2'b00, cfg.bit_ticks[15:1]} + {1'b0, cfg.bit_ticks};
		end else begin
			target = {1'b0, cfg.bit_ticks};
		end
	end

	// next state and result
	always_comb begin
		phase_n   = phase_q;
		tick_n    = tick_q;
		idx_n     = idx_q;
		shift_n   = shift_q;
		fill_n    = fill_q;
		res_valid = 1'b0;
		res       = '0;
		res.data_byte = shift_q;
		unique case (phase_q)
			PH_RECV: begin
				tick_n = tick_inc;
				if (tick_inc >= target) begin
					tick_n = '0;
					if (!idx_q[3]) begin
						shift_n = shift_q | (8'(level) << idx_q[2:0]);
						idx_n   = idx_q + 4'd1;
					end else begin
						res_valid = 1'b1;
						idx_n     = '0;
						if (level) begin
							if (fill_q < FILL_W'(BUF_DEPTH)) begin
								res.stored = 1'b1;
								res.slot   = fill_ext[5:0];
								fill_n     = fill_q + FILL_W'(1);
							end else begin
								res.overflow = 1'b1;
								fill_n       = '0;
							end
							phase_n = PH_IDLE;
						end else begin
							res.framing_error = 1'b1;
							fill_n  = '0;
							phase_n = (cfg.holdoff_ticks == 17'd0) ? PH_IDLE : PH_HOLD;
						end
					end
				end
			end
			PH_HOLD: begin
				tick_n = tick_inc;
				if (tick_inc >= cfg.holdoff_ticks) begin
					tick_n  = '0;
					phase_n = PH_IDLE;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (prev_q && !level) begin
					phase_n = PH_RECV;
					tick_n  = '0;
					idx_n   = '0;
					shift_n = '0;
				end
			end
		endcase
	end

	// advance the state once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			idx_q   <= '0;
			shift_q <= '0;
			prev_q  <= 1'b1;
			fill_q  <= '0;
		end else if (en) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			idx_q   <= idx_n;
			shift_q <= shift_n;
			prev_q  <= level;
			fill_q  <= fill_n;
		end
	end

endmodule

// ===== rtl/core/uart_rx_deframer.sv =====
// UART 8N1 receive deframer: takes one line sample word per cycle and emits
// one result word per received frame (byte, buffer slot and status flags).
// Throughput is one sample word per clock unless results stall; each word is
// held in the input register and the frame state machine loads the result
// register as it advances. A stalled result register holds the input
// register, so samples pause only while a result waits and a new one is due.
// Depends on uartrx_pkg, uartrx_cfg and uartrx_fsm.
module uart_rx_deframer #(
	parameter int BUF_DEPTH = uartrx_pkg::BUF_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [0] rx_level, [7:1] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // [7:0] data_byte, [13:8] slot
	output logic [2:0]                        m_tuser,   // [0] framing_error, [1] stored,
	                                                     // [2] overflow
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [uartrx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uartrx_pkg::CFG_DATA_W-1:0] cfg_data
);

	uartrx_pkg::cfg_t    cfg;
	uartrx_pkg::result_t res;
	uartrx_pkg::result_t res_q;
	logic                res_valid;
	logic                valid_s1;
	logic                level_s1;
	logic                advance;
	logic                m_valid_q;

	assign cfg_ready = 1'b1;

	uartrx_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// process the held word unless its result would overwrite a waiting one
	assign advance  = valid_s1 && (!res_valid || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1 <= s_tdata[0];
		end
	end

	uartrx_fsm #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.level     (level_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register: load a new result, drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, res_q.slot, res_q.data_byte};
	assign m_tuser  = {res_q.overflow, res_q.stored, res_q.framing_error};

`ifndef ASSERT_OFF
	// every result carries exactly one status flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(m_tuser))
		else $error("result without exactly one status flag");

	// slot is zero unless the byte was stored
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[13:8] == 6'd0))
		else $error("nonzero slot on unstored byte");

	// a held sample word stays held until processed
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input word lost while stalled");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for uart_rx_deframer: streams line sample words and register
// writes, predicts every received frame and checks each result word field by field.
// Depends on uartrx_pkg and the uart_rx_deframer RTL.
module tb;

	localparam logic [uartrx_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
	localparam logic [uartrx_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;
	localparam int SETTLE_CYC = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int SINK_HOLD_CYC = 400;
	localparam int RANDOM_TICKS = 200;
	localparam int RANDOM_FRAMES = 3;

	typedef enum logic [1:0] {LN_IDLE, LN_FRAME, LN_HOLD} line_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h01;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [uartrx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [uartrx_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	uart_rx_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// pending line samples and expected frame results
	logic line_q[$];
	uartrx_pkg::result_t frame_results[$];
	int ticks_queued = 0;
	int results_due = 0;
	int err_cnt = 0;
	int cyc = 0;
	int idle_cyc = 0;
	logic src_acc = 1'b0;
	logic hold_sink = 1'b0;
	logic hold_done = 1'b0;
	int sink_hold = 0;
	wire quiet = (cyc >= 250) && (cyc < 650);

	// predictor copy of the registers and the deframer state
	logic [15:0] bt_cfg = uartrx_pkg::BIT_TICKS_RST;
	logic [16:0] hold_cfg = uartrx_pkg::HOLDOFF_TICKS_RST;
	line_state_t ln_state = LN_IDLE;
	logic [16:0] tick_cnt = '0;
	logic [3:0] bit_cnt = '0;
	logic [7:0] rx_shift = '0;
	logic prev_lvl = 1'b1;
	int buf_fill = 0;

	task automatic flag_error(input string msg);
		$display("tb: mismatch: %s", msg);
		err_cnt++;
	endtask

	// advance the predicted deframer by one line sample
	task automatic deframe_tick(input logic lvl);
		int goal;
		uartrx_pkg::result_t r;
		case (ln_state)
		LN_FRAME: begin
			// first data bit sits half a bit further out from the start edge
			goal = (bit_cnt == 0) ? int'(bt_cfg >> 1) + int'(bt_cfg) : int'(bt_cfg);
			tick_cnt = tick_cnt + 17'd1;
			if (int'(tick_cnt) >= goal) begin
				tick_cnt = '0;
				if (bit_cnt < 8) begin
					rx_shift[bit_cnt[2:0]] = lvl;
					bit_cnt = bit_cnt + 4'd1;
				end else begin
					r = '0;
					r.data_byte = rx_shift;
					if (lvl) begin
						if (buf_fill < uartrx_pkg::BUF_DEPTH_DEF) begin
							r.stored = 1'b1;
							r.slot = 6'(buf_fill);
							buf_fill++;
						end else begin
							r.overflow = 1'b1;
							buf_fill = 0;
						end
						ln_state = LN_IDLE;
					end else begin
						r.framing_error = 1'b1;
						buf_fill = 0;
						ln_state = (hold_cfg == 0) ? LN_IDLE : LN_HOLD;
					end
					frame_results.push_back(r);
					results_due++;
					bit_cnt = '0;
				end
			end
		end
		LN_HOLD: begin
			tick_cnt = tick_cnt + 17'd1;
			if (tick_cnt >= hold_cfg) begin
				tick_cnt = '0;
				ln_state = LN_IDLE;
			end
		end
		default: begin
			if (prev_lvl && !lvl) begin
				ln_state = LN_FRAME;
				tick_cnt = '0;
				bit_cnt = '0;
				rx_shift = '0;
			end
		end
		endcase
		prev_lvl = lvl;
	endtask

	task automatic hold_line(input logic lvl, input int n);
		repeat (n) begin
			line_q.push_back(lvl);
			ticks_queued++;
		end
	endtask

	// queue one 8N1 frame, each bit held for one bit period, the stop bit stretched
	task automatic send_frame(input int bt, input logic [7:0] b, input logic stop_hi,
			input int stretch);
		int w;
		w = (bt < 1) ? 1 : bt;
		hold_line(1'b0, w);
		for (int k = 0; k < 8; k++)
			hold_line(b[k], w);
		hold_line(stop_hi, w + stretch);
	endtask

	// wait until every sample is taken and every result has come back
	task automatic drain_line();
		while (line_q.size() > 0 || s_tvalid)
			@(posedge clk);
		while (frame_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [uartrx_pkg::CFG_IDX_W-1:0] idx,
			input logic [uartrx_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		uartrx_pkg::REG_BIT_TICKS: bt_cfg = val[15:0];
		uartrx_pkg::REG_HOLDOFF_TICKS: hold_cfg = val;
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drive sample words from the pending queue, idling now and then
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || src_acc) begin
				if (line_q.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
					s_tdata <= {7'd0, line_q.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold <= sink_hold - 1;
			end else if (hold_sink && !hold_done) begin
				hold_done <= 1'b1;
				sink_hold <= SINK_HOLD_CYC;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 7);
			end
		end
	end

	// sample handshakes, predict, check results, watch for a hang
	always @(posedge clk) begin : monitor_blk
		uartrx_pkg::result_t got, want;
		if (arst_n) begin
			cyc <= cyc + 1;
			src_acc <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				deframe_tick(s_tdata[0]);
			if (m_tvalid && m_tready) begin
				got.data_byte = m_tdata[7:0];
				got.slot = m_tdata[13:8];
				got.framing_error = m_tuser[0];
				got.stored = m_tuser[1];
				got.overflow = m_tuser[2];
				if (frame_results.size() == 0) begin
					flag_error($sformatf("result word %h/%h with nothing expected",
						m_tdata, m_tuser));
				end else begin
					want = frame_results.pop_front();
					if (got.data_byte !== want.data_byte)
						flag_error($sformatf("data_byte %h, want %h", got.data_byte,
							want.data_byte));
					if (got.framing_error !== want.framing_error)
						flag_error($sformatf("framing_error %b, want %b",
							got.framing_error, want.framing_error));
					if (got.stored !== want.stored)
						flag_error($sformatf("stored %b, want %b", got.stored, want.stored));
					if (got.slot !== want.slot)
						flag_error($sformatf("slot %0d, want %0d", got.slot, want.slot));
					if (got.overflow !== want.overflow)
						flag_error($sformatf("overflow %b, want %b", got.overflow,
							want.overflow));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cyc <= 0;
			else
				idle_cyc <= idle_cyc + 1;
			if (idle_cyc >= STALL_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin : stim
		int bt, hold, nfr, w, gap, r, tick0, res0;
		logic good;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset bit rate: first data bit lands one and a half periods after the edge
		hold_line(1'b1, 3);
		hold_line(1'b0, 152);
		hold_line(1'b1, 12);
		drain_line();
		// retime the rest of that frame in flight
		write_reg(uartrx_pkg::REG_BIT_TICKS, 17'd2);
		hold_line(1'b1, 30);
		drain_line();

		// zero bit period and zero holdoff: one sample per bit, no dead time
		write_reg(uartrx_pkg::REG_BIT_TICKS, 17'd0);
		write_reg(uartrx_pkg::REG_HOLDOFF_TICKS, 17'd0);
		hold_line(1'b1, 2);
		send_frame(0, 8'h00, 1'b1, 0);
		send_frame(0, 8'hFF, 1'b1, 0);
		send_frame(0, 8'h5A, 1'b0, 0);
		hold_line(1'b1, 1);
		send_frame(0, 8'h81, 1'b1, 2);
		drain_line();

		// short bit period: bad stop, edge inside holdoff, then a clean frame
		write_reg(uartrx_pkg::REG_BIT_TICKS, 17'd4);
		write_reg(uartrx_pkg::REG_HOLDOFF_TICKS, 17'd5);
		hold_line(1'b1, 2);
		send_frame(4, 8'h3C, 1'b0, 0);
		hold_line(1'b1, 2);
		hold_line(1'b0, 3);
		hold_line(1'b1, 8);
		send_frame(4, 8'hC3, 1'b1, 0);
		drain_line();

		// largest registers, unmapped indexes, then retime a frame in flight
		write_reg(uartrx_pkg::REG_BIT_TICKS, 17'd65535);
		write_reg(uartrx_pkg::REG_HOLDOFF_TICKS, 17'h1FFFF);
		write_reg(REG_UNMAPPED_2, 17'h1FFFF);
		write_reg(REG_UNMAPPED_3, 17'h1FFFF);
		hold_line(1'b1, 2);
		hold_line(1'b0, 40);
		repeat (20) hold_line(1'($urandom_range(1)), 1);
		drain_line();
		write_reg(uartrx_pkg::REG_BIT_TICKS, 17'd3);
		hold_line(1'b0, 30);
		repeat (20) begin
			hold_line(1'b1, 1);
			hold_line(1'b0, 1);
		end
		drain_line();
		// shorten the holdoff while it runs
		write_reg(uartrx_pkg::REG_HOLDOFF_TICKS, 17'd7);
		hold_line(1'b1, 3);
		send_frame(3, 8'h96, 1'b1, 0);
		drain_line();

		// back-to-back frames past the buffer depth, sink held off meanwhile
		write_reg(uartrx_pkg::REG_BIT_TICKS, 17'd1);
		write_reg(uartrx_pkg::REG_HOLDOFF_TICKS, 17'd0);
		hold_line(1'b1, 1);
		send_frame(1, 8'h00, 1'b0, 0);
		hold_line(1'b1, 1);
		hold_sink = 1'b1;
		repeat (uartrx_pkg::BUF_DEPTH_DEF + 6) send_frame(1, 8'($urandom), 1'b1, 0);
		drain_line();

		// random phases: new registers each phase, mostly clean frames
		tick0 = ticks_queued;
		res0 = results_due;
		while (ticks_queued - tick0 < RANDOM_TICKS || results_due - res0 < RANDOM_FRAMES) begin
			r = $urandom_range(99);
			if (r < 10)
				bt = $urandom_range(3, 0);
			else if (r < 85)
				bt = $urandom_range(8, 4);
			else
				bt = $urandom_range(24, 9);
			w = (bt < 1) ? 1 : bt;
			hold = ($urandom_range(99) < 20) ? 0 : $urandom_range(2 * w + 4, 1);
			write_reg(uartrx_pkg::REG_BIT_TICKS, 17'(bt));
			write_reg(uartrx_pkg::REG_HOLDOFF_TICKS, 17'(hold));
			nfr = $urandom_range(5, 2);
			good = 1'b1;
			repeat (nfr) begin
				if ($urandom_range(99) < 8) begin
					// line noise
					repeat ($urandom_range(30, 4)) hold_line(1'($urandom_range(1)), 1);
					good = 1'b0;
				end else begin
					// clear the holdoff before the next start edge, mostly
					if (good)
						gap = $urandom_range(4, 0);
					else if ($urandom_range(99) < 80)
						gap = hold + $urandom_range(3, 1);
					else
						gap = $urandom_range(hold + 2, 0);
					hold_line(1'b1, gap);
					good = $urandom_range(99) >= 12;
					send_frame(bt, 8'($urandom), good, $urandom_range(3, 0));
				end
			end
			drain_line();
		end

		if (err_cnt == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
